>>> hw/rtl/hsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, codes and bit-position tables of the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int WORD_W        = 63;
    localparam int LEN_W         = 6;
    localparam int CODE_BITS_MAX = 63;
    localparam int DATA_BITS_MAX = 57;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 80;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_BIT_COUNT = 1'b1;

    localparam logic [LEN_W-1:0] BIT_COUNT_RESET = 6'd1;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  code_len;
        logic [LEN_W-1:0]  out_len;
    } hsc_s1_t;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  code_len;
        logic [LEN_W-1:0]  out_len;
        logic [LEN_W-1:0]  syn;
    } hsc_s2_t;

    typedef struct packed {
        logic              out_of_range;
        logic [LEN_W-1:0]  syndrome;
        logic [LEN_W-1:0]  out_length;
        logic [WORD_W-1:0] out_word;
    } hsc_res_t;

    // number of powers of two in 1..v
    function automatic logic [LEN_W-1:0] pow2_count(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (v[i])
            begin
                cnt = LEN_W'(i + 1);
            end
        end
        return cnt;
    endfunction

    // entry k: code position of data bit k (1-based k); entry 0 is 0
    function automatic logic [64*LEN_W-1:0] build_pos_tab();
        logic [64*LEN_W-1:0] tab;
        int k;
        tab = '0;
        k = 0;
        for (int p = 1; p <= CODE_BITS_MAX; p++) begin
            if ((p & (p - 1)) != 0)
            begin
                k = k + 1;
                tab[k*LEN_W +: LEN_W] = LEN_W'(p);
            end
        end
        return tab;
    endfunction

    localparam logic [64*LEN_W-1:0] POS_TAB = build_pos_tab();

    // code bits whose position has bit q set
    function automatic logic [WORD_W-1:0] qmask(input int q);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (((p >> q) & 1) != 0)
            begin
                m[p-1] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hamming_sec_codec_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_sec_codec_core
// Variable-length Hamming SEC encoder / decoder, three-stage pipeline.
//
// Input stream s_axis carries one word per beat (bits 62:0 of tdata). Output
// stream m_axis returns one result word per input word, in order. mode and
// bit_count are set through the cfg write port (index 0 mode, 1 bit_count),
// which the user must write only while the core is idle; the core does not enforce it.
// Each accepted word is registered in prep, parity trees and fix/output before
// m_axis_tvalid rises. Throughput: one word per cycle unless m_axis stalls;
// the three register stages (prep, parity trees, fix/output) advance together.
// Reset: pipeline emptied, mode = encode, bit_count = 1.
// Stall: when m_axis_tready is low with a result pending, all stages hold and
// s_axis_tready drops in the same cycle; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core #(
    parameter int MAX_CODE_BITS = hsc_pkg::CODE_BITS_MAX
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_index,
    input  wire logic [hsc_pkg::LEN_W-1:0]          cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [hsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // in_word[62:0]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [hsc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata   // out_word[62:0],
                                                                   // out_length[68:63],
                                                                   // syndrome[74:69],
                                                                   // out_of_range[75]
);

    logic                          mode_reg;
    logic [hsc_pkg::LEN_W-1:0]     bit_count_reg;
    logic                          en;
    logic                          v1;
    logic                          v2;
    logic                          v3;
    hsc_pkg::hsc_s1_t              s1;
    hsc_pkg::hsc_s2_t              s2;
    hsc_pkg::hsc_res_t             res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= hsc_pkg::MODE_ENCODE;
            bit_count_reg <= hsc_pkg::BIT_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hsc_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                hsc_pkg::REG_BIT_COUNT: bit_count_reg <= cfg_data;
                default:                mode_reg      <= mode_reg;
            endcase
        end
    end

    assign en            = !v3 || m_axis_tready;
    assign s_axis_tready = en;

    hsc_prep #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_word   (s_axis_tdata[hsc_pkg::WORD_W-1:0]),
        .mode      (mode_reg),
        .bit_count (bit_count_reg),
        .valid     (v1),
        .stage     (s1)
    );

    hsc_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1),
        .in_stage (s1),
        .valid    (v2),
        .stage    (s2)
    );

    hsc_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2),
        .in_stage (s2),
        .valid    (v3),
        .res      (res)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = {4'b0000, res.out_of_range, res.syndrome,
                            res.out_length, res.out_word};

endmodule
`default_nettype wire

>>> hw/rtl/hsc_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_prep
// Stage 1: length saturation, input masking and data-bit scatter.
// ----------------------------------------------------------------------------
module hsc_prep #(
    parameter int MAX_CODE_BITS = hsc_pkg::CODE_BITS_MAX
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [hsc_pkg::WORD_W-1:0]  in_word,
    input  wire logic                        mode,
    input  wire logic [hsc_pkg::LEN_W-1:0]   bit_count,
    output logic                             valid,
    output hsc_pkg::hsc_s1_t                 stage
);

    localparam logic [hsc_pkg::LEN_W-1:0] MAX_LEN = hsc_pkg::LEN_W'(MAX_CODE_BITS);
    localparam logic [hsc_pkg::LEN_W-1:0] DATA_CAP =
        MAX_LEN - hsc_pkg::pow2_count(MAX_LEN);

    logic                            valid_reg;
    hsc_pkg::hsc_s1_t                stage_reg;
    hsc_pkg::hsc_s1_t                stage_next;
    logic [hsc_pkg::LEN_W-1:0]       placed;
    logic [hsc_pkg::LEN_W-1:0]       dec_len;
    logic [hsc_pkg::LEN_W-1:0]       enc_len;
    logic [hsc_pkg::WORD_W-1:0]      data_m;
    logic [hsc_pkg::WORD_W-1:0]      code_m;
    logic [hsc_pkg::WORD_W-1:0]      scat;
    logic [8:0]                      tab_idx;

    assign placed  = (bit_count > DATA_CAP) ? DATA_CAP : bit_count;
    assign dec_len = (bit_count > MAX_LEN) ? MAX_LEN : bit_count;
    assign tab_idx = {3'b000, placed} * 9'd6;
    assign enc_len = hsc_pkg::POS_TAB[tab_idx +: hsc_pkg::LEN_W];

    assign data_m = in_word & ({hsc_pkg::WORD_W{1'b1}} >> (7'd63 - {1'b0, placed}));
    assign code_m = in_word & ({hsc_pkg::WORD_W{1'b1}} >> (7'd63 - {1'b0, dec_len}));

    always_comb
    begin
        scat = '0;
        for (int i = 0; i < hsc_pkg::DATA_BITS_MAX; i++) begin
            scat[hsc_pkg::POS_TAB[(i+1)*hsc_pkg::LEN_W +: hsc_pkg::LEN_W] - 1] = data_m[i];
        end
    end

    always_comb
    begin
        stage_next.mode = mode;
        if (mode == hsc_pkg::MODE_ENCODE)
        begin
            stage_next.word     = scat;
            stage_next.code_len = enc_len;
            stage_next.out_len  = enc_len;
        end
        else
        begin
            stage_next.word     = code_m;
            stage_next.code_len = dec_len;
            stage_next.out_len  = dec_len - hsc_pkg::pow2_count(dec_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule
`default_nettype wire

>>> hw/rtl/hsc_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_check
// Stage 2: six parity trees; parity bits when encoding, syndrome when decoding.
// ----------------------------------------------------------------------------
module hsc_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire hsc_pkg::hsc_s1_t  in_stage,
    output logic                   valid,
    output hsc_pkg::hsc_s2_t       stage
);

    logic                          valid_reg;
    hsc_pkg::hsc_s2_t              stage_reg;
    logic [hsc_pkg::LEN_W-1:0]     syn_next;

    always_comb
    begin
        for (int q = 0; q < hsc_pkg::LEN_W; q++) begin
            syn_next[q] = ^(in_stage.word & hsc_pkg::qmask(q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg.mode     <= in_stage.mode;
            stage_reg.word     <= in_stage.word;
            stage_reg.code_len <= in_stage.code_len;
            stage_reg.out_len  <= in_stage.out_len;
            stage_reg.syn      <= syn_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule
`default_nettype wire

>>> hw/rtl/hsc_fix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_fix
// Stage 3: parity insertion or bit correction and data gather; output register.
// ----------------------------------------------------------------------------
module hsc_fix (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire hsc_pkg::hsc_s2_t  in_stage,
    output logic                   valid,
    output hsc_pkg::hsc_res_t      res
);

    logic                          valid_reg;
    hsc_pkg::hsc_res_t             res_reg;
    hsc_pkg::hsc_res_t             res_next;
    logic [hsc_pkg::WORD_W-1:0]    par_word;
    logic [hsc_pkg::WORD_W-1:0]    flip;
    logic [hsc_pkg::WORD_W-1:0]    corr;
    logic [hsc_pkg::WORD_W-1:0]    gath;
    logic                          oor;

    always_comb
    begin
        par_word = '0;
        for (int q = 0; q < hsc_pkg::LEN_W; q++) begin
            par_word[(1 << q) - 1] = in_stage.syn[q];
        end
    end

    assign oor  = in_stage.syn > in_stage.code_len;
    assign flip = ((in_stage.syn != '0) && !oor) ?
                  ({{(hsc_pkg::WORD_W-1){1'b0}}, 1'b1} << (in_stage.syn - 6'd1)) : '0;
    assign corr = in_stage.word ^ flip;

    always_comb
    begin
        gath = '0;
        for (int j = 0; j < hsc_pkg::DATA_BITS_MAX; j++) begin
            gath[j] = corr[hsc_pkg::POS_TAB[(j+1)*hsc_pkg::LEN_W +: hsc_pkg::LEN_W] - 1];
        end
    end

    always_comb
    begin
        res_next.out_length = in_stage.out_len;
        if (in_stage.mode == hsc_pkg::MODE_ENCODE)
        begin
            res_next.out_word     = in_stage.word | par_word;
            res_next.syndrome     = '0;
            res_next.out_of_range = 1'b0;
        end
        else
        begin
            res_next.out_word     = gath;
            res_next.syndrome     = in_stage.syn;
            res_next.out_of_range = oor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule
`default_nettype wire

>>> bench/hamming_sec_codec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_codec_checker
// Watches the config port and both streams of the Hamming SEC codec, predicts
// each result word from its own copy of mode and bit_count, and compares every
// output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hamming_sec_codec_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [hsc_pkg::LEN_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [hsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // in_word[62:0]
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [hsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // out_word[62:0],
                                                             // out_length[68:63],
                                                             // syndrome[74:69],
                                                             // out_of_range[75]
    output int                               mismatches,
    output int                               words_due,
    output int                               encoded,
    output int                               decoded,
    output int                               fixed_bits,
    output int                               range_flags
);
    import hsc_pkg::*;

    logic             cur_mode;
    logic [LEN_W-1:0] cur_count;
    hsc_res_t         codec_outputs_due[$];
    int               fail_count;
    int               enc_seen;
    int               dec_seen;
    int               fix_seen;
    int               oor_seen;

    function automatic hsc_res_t hamming_encode(input logic [WORD_W-1:0] data,
                                                input logic [LEN_W-1:0] n);
        hsc_res_t          r;
        logic [WORD_W-1:0] code;
        logic              par;
        int                placed;
        int                len;
        code   = '0;
        placed = 0;
        len    = 0;
        for (int p = 1; p <= CODE_BITS_MAX && placed < n; p++) begin
            if ((p & (p - 1)) != 0)
            begin
                code[p-1] = data[placed];
                placed++;
                len = p;
            end
        end
        for (int q = 0; q < LEN_W; q++) begin
            if ((1 << q) <= len)
            begin
                par = 1'b0;
                for (int p = 1; p <= len; p++) begin
                    if (((p >> q) & 1) != 0 && p != (1 << q))
                    begin
                        par ^= code[p-1];
                    end
                end
                code[(1 << q) - 1] = par;
            end
        end
        r.out_word     = code;
        r.out_length   = LEN_W'(len);
        r.syndrome     = '0;
        r.out_of_range = 1'b0;
        return r;
    endfunction

    function automatic hsc_res_t hamming_decode(input logic [WORD_W-1:0] code,
                                                input logic [LEN_W-1:0] len);
        hsc_res_t          r;
        logic [WORD_W-1:0] data;
        logic              oor;
        int                syn;
        int                k;
        syn  = 0;
        k    = 0;
        data = '0;
        for (int p = 1; p <= len; p++) begin
            if (code[p-1])
            begin
                syn ^= p;
            end
        end
        oor = (syn > len);
        if (syn != 0 && !oor)
        begin
            code[syn-1] = ~code[syn-1];
        end
        for (int p = 1; p <= len; p++) begin
            if ((p & (p - 1)) != 0)
            begin
                data[k] = code[p-1];
                k++;
            end
        end
        r.out_word     = data;
        r.out_length   = LEN_W'(k);
        r.syndrome     = LEN_W'(syn);
        r.out_of_range = oor;
        return r;
    endfunction

    task automatic note_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        hsc_res_t want;
        hsc_res_t got;
        if (!rst_n)
        begin
            cur_mode  = MODE_ENCODE;
            cur_count = BIT_COUNT_RESET;
            codec_outputs_due.delete();
            fail_count = 0;
            enc_seen   = 0;
            dec_seen   = 0;
            fix_seen   = 0;
            oor_seen   = 0;
            mismatches <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cur_mode == MODE_ENCODE)
                begin
                    want = hamming_encode(s_axis_tdata[WORD_W-1:0], cur_count);
                    codec_outputs_due = {codec_outputs_due, want};
                    enc_seen++;
                end
                else
                begin
                    want = hamming_decode(s_axis_tdata[WORD_W-1:0], cur_count);
                    codec_outputs_due = {codec_outputs_due, want};
                    dec_seen++;
                    if (want.out_of_range)
                        oor_seen++;
                    else if (want.syndrome != 0)
                        fix_seen++;
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_MODE)
                    cur_mode = cfg_data[0];
                else if (cfg_index == REG_BIT_COUNT)
                    cur_count = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(hsc_res_t)-1:0];
                if (codec_outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = codec_outputs_due.pop_front();
                    note_field("out_word", want.out_word, got.out_word);
                    note_field("out_length", WORD_W'(want.out_length), WORD_W'(got.out_length));
                    note_field("syndrome", WORD_W'(want.syndrome), WORD_W'(got.syndrome));
                    note_field("out_of_range", WORD_W'(want.out_of_range),
                               WORD_W'(got.out_of_range));
                    note_field("tdata pad", '0,
                               WORD_W'(m_axis_tdata[OUT_TDATA_W-1:$bits(hsc_res_t)]));
                end
            end
            mismatches  <= fail_count;
            words_due   <= codec_outputs_due.size();
            encoded     <= enc_seen;
            decoded     <= dec_seen;
            fixed_bits  <= fix_seen;
            range_flags <= oor_seen;
        end
    end

endmodule

>>> bench/hamming_sec_codec_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_codec_core_test
// Drives the Hamming SEC codec through directed corner words and many random
// encode/decode settings, with bursty input and a stalling output side; the
// checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core_test;
    import hsc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 36;
    localparam int PHASE_WORDS   = 50;

    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_MOSTLY = 2;
    localparam int RX_SPARSE = 3;
    localparam int RX_HOLD   = 4;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_index;
    logic [LEN_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int words_due;
    int encoded;
    int decoded;
    int fixed_bits;
    int range_flags;
    int cycles;
    int burst_left;
    int settings_run;
    bit random_part;
    bit long_hold_done;

    hamming_sec_codec_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hamming_sec_codec_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .words_due     (words_due),
        .encoded       (encoded),
        .decoded       (decoded),
        .fixed_bits    (fixed_bits),
        .range_flags   (range_flags)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, words_due);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // parity bits fixed up so the first len positions form a clean codeword;
    // bits above len are left as they are
    function automatic logic [WORD_W-1:0] make_codeword(input logic [WORD_W-1:0] w,
                                                        input int len);
        logic [WORD_W-1:0] cw;
        int                syn;
        cw  = w;
        syn = 0;
        for (int p = 1; p <= len; p++) begin
            if (w[p-1])
            begin
                syn ^= p;
            end
        end
        for (int q = 0; q < LEN_W; q++) begin
            if (((syn >> q) & 1) != 0)
            begin
                cw[(1 << q) - 1] = ~cw[(1 << q) - 1];
            end
        end
        return cw;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return ALL_ONES;
        else if (pick < 12)
            return '0;
        else
            return WORD_W'({$urandom, $urandom});
    endfunction

    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input logic md, input logic [LEN_W-1:0] count);
        drain();
        write_reg(REG_MODE, LEN_W'(md));
        write_reg(REG_BIT_COUNT, count);
        burst_left = 0;
        settings_run++;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tdata  <= {1'b0, w};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_decode_word(input int len);
        logic [WORD_W-1:0] cw;
        int                pick;
        pick = $urandom_range(0, 99);
        cw   = make_codeword(rand_word(), len);
        if (len == 0 || pick < 15)
            cw = rand_word();
        else if (pick < 30)
            ;
        else if (pick < 85)
            cw[$urandom_range(1, len) - 1] ^= 1'b1;
        else
        begin
            cw[$urandom_range(1, len) - 1] ^= 1'b1;
            cw[$urandom_range(1, len) - 1] ^= 1'b1;
        end
        send_word(cw);
    endtask

    initial
    begin
        int           pick;
        logic         md;
        logic [LEN_W-1:0] count;
        logic [WORD_W-1:0] cw;
        cycles         = 0;
        burst_left     = 0;
        settings_run   = 0;
        random_part    = 1'b0;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_MODE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: encode, one data bit
        send_word('0);
        send_word(ALL_ONES);

        apply_setting(MODE_ENCODE, 6'd0);
        send_word(ALL_ONES);
        apply_setting(MODE_ENCODE, 6'd57);
        send_word('0);
        send_word(ALL_ONES);
        send_word(WORD_W'({32{2'b01}}));
        send_word(WORD_W'({32{2'b10}}));
        // longer than the code can hold
        apply_setting(MODE_ENCODE, 6'd63);
        send_word(ALL_ONES);
        send_word(rand_word());
        apply_setting(MODE_ENCODE, 6'd4);
        send_word(63'hF);

        apply_setting(MODE_DECODE, 6'd63);
        cw = make_codeword(ALL_ONES, 63);
        send_word(cw);
        send_word(cw ^ 63'h1);
        send_word(cw ^ (63'h1 << 62));
        send_word(cw ^ (63'h1 << 31));
        apply_setting(MODE_DECODE, 6'd0);
        send_word(ALL_ONES);
        apply_setting(MODE_DECODE, 6'd1);
        send_word(63'h1);
        // syndrome past the end of a 5-bit codeword, then one within it
        apply_setting(MODE_DECODE, 6'd5);
        send_word(63'h14);
        send_word(63'h1F);

        random_part = 1'b1;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            md   = ($urandom_range(0, 1) == 0) ? MODE_ENCODE : MODE_DECODE;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                count = 6'd0;
            else if (pick < 25)
                count = 6'd63;
            else if (pick < 35)
                count = LEN_W'($urandom_range(56, 62));
            else
                count = LEN_W'($urandom_range(1, 63));
            apply_setting(md, count);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (md == MODE_ENCODE)
                    send_word(rand_word());
                else
                    send_decode_word(count);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("%0d settings, %0d words encoded and %0d decoded", settings_run, encoded,
                 decoded);
        $display("decoder fixed %0d single-bit errors, flagged %0d syndromes out of range",
                 fixed_bits, range_flags);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // output side: changing stall patterns, holds among them; one long hold in
    // the random part is forced, started while the sender is offering words
    initial
    begin
        int style;
        int span;
        int pick;
        logic rdy;
        long_hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                style = RX_ALWAYS;
            else if (pick < 50)
                style = RX_COIN;
            else if (pick < 75)
                style = RX_MOSTLY;
            else if (pick < 95)
                style = RX_SPARSE;
            else
                style = RX_HOLD;
            if (random_part && !long_hold_done && s_axis_tvalid)
            begin
                style = RX_HOLD;
                long_hold_done = 1'b1;
            end
            span = $urandom_range(8, 120);
            if (style == RX_HOLD)
            begin
                span = $urandom_range(40, 90);
            end
            for (int c = 0; c < span; c++) begin
                case (style)
                    RX_ALWAYS: rdy = 1'b1;
                    RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
                    RX_SPARSE: rdy = ($urandom_range(0, 4) == 0);
                    default:   rdy = 1'b0;
                endcase
                m_axis_tready <= rdy;
                @(posedge clk);
            end
        end
    end

endmodule
